// File: hw/rtl/rprf_pkg.sv
`timescale 1ns / 1ps

package rprf_pkg;

	// Row geometry and store sizes.
	localparam int MAX_WIDTH = 512;
	localparam int TAP_DEPTH = 2 * MAX_WIDTH - 1;
	localparam int COL_AW    = $clog2(MAX_WIDTH);
	localparam int TAP_AW    = $clog2(TAP_DEPTH);
	localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

	// Fixed field widths of the ports.
	localparam int CMD_W     = 2;
	localparam int TAP_IDX_W = 10;
	localparam int COEF_W    = 32;
	localparam int COL_W     = 9;
	localparam int SMP_W     = 24;
	localparam int WGT_W     = 17;
	localparam int AW_W      = 10;

	localparam logic [AW_W-1:0] AW_RESET = AW_W'(512);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_TAP  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CALC = 2'd2;

	// Datapath widths: one signed 32 x 25 multiplier and a wide accumulator.
	localparam int MUL_B_W   = SMP_W + 1;
	localparam int PROD_W    = COEF_W + MUL_B_W;
	localparam int ACC_W     = PROD_W + $clog2(MAX_WIDTH);
	localparam int RND_SHIFT = 19;
	localparam int OUT_SHIFT = 16;
	localparam int S20_W     = ACC_W - RND_SHIFT;
	localparam int SPLIT     = SMP_W;

	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (RND_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] OUT_BIAS = ACC_W'(1 << (OUT_SHIFT - 1));

	// Operand pairing of the shared multiplier.
	typedef enum logic [1:0] {
		OP_MAC,
		OP_LO,
		OP_HI
	} rprf_op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_LO,
		ST_HI,
		ST_SETTLE,
		ST_DONE
	} rprf_state_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic     issue;
		rprf_op_t sel;
		logic     acc_clear;
		logic     round;
	} rprf_ctrl_t;

endpackage

// File: hw/rtl/rprf_ram.sv
`timescale 1ns / 1ps

module rprf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/rprf_mac.sv
`timescale 1ns / 1ps

module rprf_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rprf_pkg::rprf_ctrl_t         ctrl,
	input  logic [rprf_pkg::COEF_W-1:0]  tap_rd,
	input  logic [rprf_pkg::SMP_W-1:0]   smp_rd,
	input  logic [rprf_pkg::WGT_W-1:0]   wgt_rd,
	output logic signed [31:0]           res_value,
	output logic                         res_sat
);

	import rprf_pkg::*;

	localparam int TOP_LSB = OUT_SHIFT + 31;

	logic                       issue_s1;
	rprf_op_t                   sel_s1;
	logic                       v_s2;
	logic                       hi_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [COEF_W-1:0]   mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    addend;
	logic signed [ACC_W-1:0]    rnd_sum;
	logic signed [S20_W-1:0]    s20_q;
	logic [ACC_W-TOP_LSB-1:0]   top_bits;
	logic                       pos_ovf;
	logic                       neg_ovf;

	// Issue stage lines up with the registered read data of the stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			sel_s1   <= OP_MAC;
			v_s2     <= 1'b0;
			hi_s2    <= 1'b0;
		end else begin
			issue_s1 <= ctrl.issue;
			sel_s1   <= ctrl.sel;
			v_s2     <= issue_s1;
			hi_s2    <= (sel_s1 == OP_HI);
		end
	end

	// Operand selection: tap by sample, or one half of the rounded sum by the weight.
	always_comb begin
		unique case (sel_s1)
			OP_MAC: begin
				mul_a = signed'(tap_rd);
				mul_b = signed'({1'b0, smp_rd});
			end
			OP_LO: begin
				mul_a = signed'(COEF_W'(wgt_rd));
				mul_b = signed'({1'b0, s20_q[SPLIT-1:0]});
			end
			OP_HI: begin
				mul_a = COEF_W'(signed'(s20_q[S20_W-1:SPLIT]));
				mul_b = signed'(MUL_B_W'(wgt_rd));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// The shared multiplier, registered before the accumulator.
	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
	end

	assign addend  = hi_s2 ? (ACC_W'(prod_s2) <<< SPLIT) : ACC_W'(prod_s2);
	assign rnd_sum = acc_q + RND_BIAS;

	// Accumulator: clears at start, rounds the row sum, then collects the weighted terms.
	always_ff @(posedge clk) begin
		if (ctrl.acc_clear) begin
			acc_q <= '0;
		end else if (ctrl.round) begin
			s20_q <= rnd_sum[ACC_W-1:RND_SHIFT];
			acc_q <= OUT_BIAS;
		end else if (v_s2) begin
			acc_q <= acc_q + addend;
		end
	end

	// Final shift and clamp to the signed 32-bit range.
	assign top_bits = acc_q[ACC_W-1:TOP_LSB];
	assign pos_ovf  = !acc_q[ACC_W-1] && (|top_bits);
	assign neg_ovf  = acc_q[ACC_W-1] && !(&top_bits);
	assign res_sat  = pos_ovf || neg_ovf;

	always_comb begin
		priority if (pos_ovf) begin
			res_value = 32'sh7FFF_FFFF;
		end else if (neg_ovf) begin
			res_value = 32'sh8000_0000;
		end else begin
			res_value = signed'(acc_q[TOP_LSB:OUT_SHIFT]);
		end
	end

endmodule

// File: hw/rtl/rprf_seq.sv
`timescale 1ns / 1ps

module rprf_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [rprf_pkg::CMD_W-1:0]   cmd,
	input  logic [rprf_pkg::COL_W-1:0]   column,
	input  logic [rprf_pkg::AW_W-1:0]    active_width,
	input  logic                         out_free,
	output logic                         in_ready,
	output rprf_pkg::rprf_ctrl_t         ctrl,
	output logic                         rd_re,
	output logic [rprf_pkg::TAP_AW-1:0]  tap_raddr,
	output logic [rprf_pkg::COL_AW-1:0]  smp_raddr,
	output logic                         wgt_re,
	output logic [rprf_pkg::COL_AW-1:0]  wgt_raddr,
	output logic                         done,
	output logic [rprf_pkg::COL_AW-1:0]  col_out
);

	import rprf_pkg::*;

	rprf_state_t       state_q;
	rprf_state_t       state_d;
	logic [COL_AW-1:0] col_q;
	logic [TAP_AW-1:0] ti_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  eff_q;
	logic [CNT_W-1:0]  eff_c;
	logic              dcnt_q;
	logic              start;

	// Width in use, limited to the row size.
	assign eff_c = (32'(active_width) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(active_width);
	assign start = in_valid && (state_q == ST_IDLE) && (cmd == CMD_CALC)
		&& (32'(column) < MAX_WIDTH);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (eff_c == '0) ? ST_DRAIN : ST_MAC;
				end
			end
			ST_MAC: begin
				if (cnt_q == eff_q - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (dcnt_q) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND:  state_d = ST_LO;
			ST_LO:     state_d = ST_HI;
			ST_HI:     state_d = ST_SETTLE;
			ST_SETTLE: begin
				if (dcnt_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs decoded from the state.
	always_comb begin
		in_ready       = 1'b0;
		ctrl.issue     = 1'b0;
		ctrl.sel       = OP_MAC;
		ctrl.acc_clear = 1'b0;
		ctrl.round     = 1'b0;
		rd_re          = 1'b0;
		wgt_re         = 1'b0;
		done           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				ctrl.acc_clear = start;
				wgt_re         = start;
			end
			ST_MAC: begin
				ctrl.issue = 1'b1;
				rd_re      = 1'b1;
			end
			ST_ROUND: ctrl.round = 1'b1;
			ST_LO: begin
				ctrl.issue = 1'b1;
				ctrl.sel   = OP_LO;
			end
			ST_HI: begin
				ctrl.issue = 1'b1;
				ctrl.sel   = OP_HI;
			end
			ST_DONE: done = 1'b1;
			ST_DRAIN, ST_SETTLE: begin
			end
			default: begin
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dcnt_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DRAIN) || (state_q == ST_SETTLE)) begin
				dcnt_q <= !dcnt_q;
			end else begin
				dcnt_q <= 1'b0;
			end
		end
	end

	// Column walk: sample index counts up while the tap index counts down.
	always_ff @(posedge clk) begin
		if (start) begin
			col_q <= COL_AW'(column);
			ti_q  <= TAP_AW'(32'(column) + MAX_WIDTH - 1);
			cnt_q <= '0;
			eff_q <= eff_c;
		end else if (state_q == ST_MAC) begin
			cnt_q <= cnt_q + CNT_W'(1);
			ti_q  <= ti_q - TAP_AW'(1);
		end
	end

	assign tap_raddr = ti_q;
	assign smp_raddr = cnt_q[COL_AW-1:0];
	assign wgt_raddr = COL_AW'(column);
	assign col_out   = col_q;

endmodule

// File: hw/rtl/projection_row_ramp_filter.sv
`timescale 1ns / 1ps
// Channel  | Handshake             | Word
// ---------+-----------------------+----------------------------------------------------
// cfg      | cfg_valid / cfg_ready | cfg_data: active_width
// in       | in_valid / in_ready   | cmd, tap_index, tap_value, column, sample, weight
// out      | out_valid / out_ready | out_column, filtered_value, saturated
//
// Tap and column loads leave the input ready for the next word.
// A compute sums min(active_width, 512) products and holds the input until its result
// word has moved into the output register; the single multiply-accumulate unit
// handles one column at a time.
// Reset sets active_width to 512; the stores are not cleared.
// The result sits in an output register, so loads proceed while it waits.

module projection_row_ramp_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rprf_pkg::AW_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rprf_pkg::CMD_W-1:0]            cmd,
	input  logic [rprf_pkg::TAP_IDX_W-1:0]        tap_index,
	input  logic signed [rprf_pkg::COEF_W-1:0]    tap_value,
	input  logic [rprf_pkg::COL_W-1:0]            column,
	input  logic [rprf_pkg::SMP_W-1:0]            sample,
	input  logic [rprf_pkg::WGT_W-1:0]            weight,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rprf_pkg::COL_W-1:0]            out_column,
	output logic signed [31:0]                    filtered_value,
	output logic                                  saturated
);

	import rprf_pkg::*;

	logic [AW_W-1:0]    aw_q;
	logic               accept;
	logic               tap_we;
	logic               col_we;
	logic               out_free;
	logic               done;
	rprf_ctrl_t         ctrl;
	logic               rd_re;
	logic               wgt_re;
	logic [TAP_AW-1:0]  tap_raddr;
	logic [COL_AW-1:0]  smp_raddr;
	logic [COL_AW-1:0]  wgt_raddr;
	logic [COL_AW-1:0]  col_out;
	logic [COEF_W-1:0]  tap_rd;
	logic [SMP_W-1:0]   smp_rd;
	logic [WGT_W-1:0]   wgt_rd;
	logic signed [31:0] res_value;
	logic               res_sat;
	logic               out_valid_q;
	logic [COL_W-1:0]   out_column_q;
	logic signed [31:0] filtered_q;
	logic               saturated_q;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= AW_RESET;
		end else if (cfg_valid) begin
			aw_q <= cfg_data;
		end
	end

	// Store writes for load commands; out-of-range indexes are dropped.
	assign accept = in_valid && in_ready;
	assign tap_we = accept && (cmd == CMD_TAP) && (32'(tap_index) < TAP_DEPTH);
	assign col_we = accept && (cmd == CMD_COL) && (32'(column) < MAX_WIDTH);

	rprf_ram #(
		.WIDTH(COEF_W),
		.DEPTH(TAP_DEPTH)
	) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (TAP_AW'(tap_index)),
		.wdata (tap_value),
		.re    (rd_re),
		.raddr (tap_raddr),
		.rdata (tap_rd)
	);

	rprf_ram #(
		.WIDTH(SMP_W),
		.DEPTH(MAX_WIDTH)
	) u_smp_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (COL_AW'(column)),
		.wdata (sample),
		.re    (rd_re),
		.raddr (smp_raddr),
		.rdata (smp_rd)
	);

	rprf_ram #(
		.WIDTH(WGT_W),
		.DEPTH(MAX_WIDTH)
	) u_wgt_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (COL_AW'(column)),
		.wdata (weight),
		.re    (wgt_re),
		.raddr (wgt_raddr),
		.rdata (wgt_rd)
	);

	rprf_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.cmd          (cmd),
		.column       (column),
		.active_width (aw_q),
		.out_free     (out_free),
		.in_ready     (in_ready),
		.ctrl         (ctrl),
		.rd_re        (rd_re),
		.tap_raddr    (tap_raddr),
		.smp_raddr    (smp_raddr),
		.wgt_re       (wgt_re),
		.wgt_raddr    (wgt_raddr),
		.done         (done),
		.col_out      (col_out)
	);

	rprf_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.tap_rd    (tap_rd),
		.smp_rd    (smp_rd),
		.wgt_rd    (wgt_rd),
		.res_value (res_value),
		.res_sat   (res_sat)
	);

	// Output register decouples the result word from the next command.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_column_q <= COL_W'(col_out);
			filtered_q   <= res_value;
			saturated_q  <= res_sat;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_column     = out_column_q;
	assign filtered_value = filtered_q;
	assign saturated      = saturated_q;

endmodule

// File: hw/rtl/rprf_checker.sv
`timescale 1ns / 1ps

module rprf_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic [rprf_pkg::CMD_W-1:0]            cmd,
	input logic [rprf_pkg::COL_W-1:0]            column,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [rprf_pkg::COL_W-1:0]            out_column,
	input logic signed [31:0]                    filtered_value,
	input logic                                  saturated
);

	import rprf_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_column)
			&& $stable(filtered_value) && $stable(saturated)))
		else $error("result word changed while stalled");

	// A clipped result sits at one of the range limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (filtered_value == 32'sh7FFF_FFFF
			|| filtered_value == 32'sh8000_0000))
		else $error("saturated flag without a limit value");

	// An accepted compute for a valid column makes the block busy.
	a_calc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd == CMD_CALC && 32'(column) < MAX_WIDTH) |=> !in_ready)
		else $error("compute accepted but block not busy");

	// Every other command leaves the input ready for the next word.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd != CMD_CALC) |=> in_ready)
		else $error("load command stalled the input");

endmodule

bind projection_row_ramp_filter rprf_checker u_rprf_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import rprf_pkg::*;

	// Unused command code: the block takes the word and does nothing with it.
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	localparam int DIRECTED_ROWS   = 21;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int HOLD_PHASE      = 2;
	localparam int RAND_WIDTH_PHASE = 7;
	localparam int LONG_HOLD       = 2000;
	localparam int SETTLE_CYCLES   = 16;
	localparam int END_DRAIN       = MAX_WIDTH + 16;
	localparam int CYCLE_LIMIT     = 8_000_000;
	localparam int ROUND_Q20       = 19;
	localparam int SCALE_Q16       = 16;

	localparam logic signed [95:0] VALUE_MAX = 96'sd2147483647;
	localparam logic signed [95:0] VALUE_MIN = -VALUE_MAX - 96'sd1;

	// One input word, with an optional hand-written expectation for computes.
	typedef struct packed {
		logic [CMD_W-1:0]     op;
		logic [TAP_IDX_W-1:0] tap_idx;
		logic [COEF_W-1:0]    tap_val;
		logic [COL_W-1:0]     col;
		logic [SMP_W-1:0]     smp;
		logic [WGT_W-1:0]     wgt;
		logic                 known;
		logic [31:0]          known_val;
		logic                 known_sat;
	} row_word_t;

	// One filtered column as it should leave the block.
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [31:0]      value;
		logic             sat;
	} col_result_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [AW_W-1:0]         cfg_data = AW_RESET;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [CMD_W-1:0]        cmd = CMD_NOP;
	logic [TAP_IDX_W-1:0]    tap_index = '0;
	logic signed [COEF_W-1:0] tap_value = '0;
	logic [COL_W-1:0]        column = '0;
	logic [SMP_W-1:0]        sample = '0;
	logic [WGT_W-1:0]        weight = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [COL_W-1:0]        out_column;
	logic signed [31:0]      filtered_value;
	logic                    saturated;

	// Mirror of the block's stores and register.
	logic signed [31:0] tap_mem [TAP_DEPTH];
	logic [SMP_W-1:0]   sample_mem [MAX_WIDTH];
	logic [WGT_W-1:0]   weight_mem [MAX_WIDTH];
	logic [AW_W-1:0]    row_width = AW_RESET;

	col_result_t pending_results [$];
	row_word_t   directed_rows [DIRECTED_ROWS];
	int          phase_width [PHASES] = '{512, 2, 17, 1023, 0, 1, 600, 2, 64, 512};

	int error_count = 0;
	int send_idle_pct = 7;
	int recv_idle_pct = 57;
	logic hold_request = 1'b0;
	int hold_left = 0;
	logic hold_used = 1'b0;
	int cycle_count = 0;

	projection_row_ramp_filter uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ramp convolution of one column: exact sum, rounded to Q.20, weighted, clamped.
	function automatic col_result_t filter_column(input logic [COL_W-1:0] col);
		col_result_t r;
		int span;
		logic signed [95:0] acc, tap_x, smp_x, s20, res;
		span = (row_width > MAX_WIDTH) ? MAX_WIDTH : int'(row_width);
		acc = '0;
		for (int k = 0; k < span; k++) begin
			tap_x = tap_mem[int'(col) + MAX_WIDTH - 1 - k];
			smp_x = {72'd0, sample_mem[k]};
			acc += tap_x * smp_x;
		end
		s20 = (acc + (96'sd1 <<< (ROUND_Q20 - 1))) >>> ROUND_Q20;
		res = (s20 * $signed({79'd0, weight_mem[col]}) + (96'sd1 <<< (SCALE_Q16 - 1)))
			>>> SCALE_Q16;
		r.column = col;
		r.sat = 1'b0;
		if (res > VALUE_MAX) begin
			res = VALUE_MAX;
			r.sat = 1'b1;
		end else if (res < VALUE_MIN) begin
			res = VALUE_MIN;
			r.sat = 1'b1;
		end
		r.value = res[31:0];
		return r;
	endfunction

	function automatic row_word_t make_row(input logic [CMD_W-1:0] op,
			input logic [TAP_IDX_W-1:0] idx, input logic [COEF_W-1:0] val,
			input logic [COL_W-1:0] col, input logic [SMP_W-1:0] smp,
			input logic [WGT_W-1:0] wgt);
		row_word_t w;
		w = '0;
		w.op = op;
		w.tap_idx = idx;
		w.tap_val = val;
		w.col = col;
		w.smp = smp;
		w.wgt = wgt;
		return w;
	endfunction

	function automatic row_word_t calc_known(input logic [COL_W-1:0] col,
			input logic [31:0] val, input logic sat);
		row_word_t w;
		w = make_row(CMD_CALC, '0, '0, col, '0, '0);
		w.known = 1'b1;
		w.known_val = val;
		w.known_sat = sat;
		return w;
	endfunction

	// Taps of mixed magnitude, so that some sums stay in range and some clip.
	function automatic logic [31:0] shaped_tap();
		int sh;
		sh = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 9) : $urandom_range(10, 31);
		return $signed($urandom) >>> sh;
	endfunction

	function automatic logic [WGT_W-1:0] random_weight();
		if ($urandom_range(0, 99) < 80)
			return WGT_W'($urandom_range(0, 65536));
		return WGT_W'($urandom);
	endfunction

	function automatic row_word_t random_row_word();
		row_word_t w;
		int roll;
		w = make_row(CMD_NOP, TAP_IDX_W'($urandom), $urandom, COL_W'($urandom),
			SMP_W'($urandom), WGT_W'($urandom));
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			w.op = CMD_TAP;
			w.tap_idx = ($urandom_range(0, 99) < 4) ? TAP_IDX_W'(TAP_DEPTH)
				: TAP_IDX_W'($urandom_range(0, TAP_DEPTH - 1));
			w.tap_val = shaped_tap();
		end else if (roll < 63) begin
			w.op = CMD_COL;
			w.wgt = random_weight();
		end else if (roll < 97) begin
			w.op = CMD_CALC;
		end
		return w;
	endfunction

	// Offer one word, wait for it to be taken, then update the mirror.
	task automatic offer_word(input row_word_t w);
		col_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= w.op;
		tap_index <= w.tap_idx;
		tap_value <= w.tap_val;
		column    <= w.col;
		sample    <= w.smp;
		weight    <= w.wgt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		case (w.op)
			CMD_TAP: begin
				if (w.tap_idx < TAP_DEPTH)
					tap_mem[w.tap_idx] = w.tap_val;
			end
			CMD_COL: begin
				sample_mem[w.col] = w.smp;
				weight_mem[w.col] = w.wgt;
			end
			CMD_CALC: begin
				r = filter_column(w.col);
				if (w.known) begin
					r.value = w.known_val;
					r.sat = w.known_sat;
				end
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic write_width(input logic [AW_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		row_width = value;
	endtask

	// Stop sending and wait until every expected word has come back.
	task automatic drain_row_results(input int extra);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_request && !hold_used) begin
			hold_used = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Score each result word against the oldest expectation.
	always @(posedge clk) begin
		col_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result word: col %0d value %0d sat %0b",
						out_column, filtered_value, saturated);
			end else begin
				want = pending_results.pop_front();
				if (out_column !== want.column || filtered_value !== want.value
						|| saturated !== want.sat) begin
					error_count++;
					if (error_count <= 10)
						$display("result mismatch: col %0d/%0d value %0d/%0d sat %0b/%0b (exp/act)",
							want.column, out_column, $signed(want.value), filtered_value,
							want.sat, saturated);
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int mode;
		int idle_mode;
		idle_mode = 0;

		// Hand-picked words on a two-column row: extreme taps, samples and weights,
		// clipping both ways, the top of the tap table, a tap index past the table,
		// a column beyond the width and the unused command.
		directed_rows = '{
			make_row(CMD_TAP, 10'd511, 32'h7FFF_FFFF, 9'd0, 24'd0, 17'd0),
			make_row(CMD_TAP, 10'd510, 32'h8000_0000, 9'd0, 24'd0, 17'd0),
			make_row(CMD_TAP, 10'd512, 32'h0010_0000, 9'd0, 24'd0, 17'd0),
			make_row(CMD_TAP, 10'd1022, 32'h0000_0005, 9'd0, 24'd0, 17'd0),
			make_row(CMD_TAP, 10'd1021, 32'hFFFF_FFFF, 9'd0, 24'd0, 17'd0),
			make_row(CMD_TAP, 10'd1023, 32'h1234_5678, 9'd0, 24'd0, 17'd0),
			make_row(CMD_COL, 10'd0, 32'd0, 9'd0, 24'hFF_FFFF, 17'h1_FFFF),
			make_row(CMD_COL, 10'd0, 32'd0, 9'd1, 24'd0, 17'd0),
			calc_known(9'd0, 32'h7FFF_FFFF, 1'b1),
			calc_known(9'd1, 32'd0, 1'b0),
			make_row(CMD_COL, 10'd0, 32'd0, 9'd1, 24'hFF_FFFF, 17'h1_0000),
			make_row(CMD_CALC, 10'd0, 32'd0, 9'd0, 24'd0, 17'd0),
			calc_known(9'd1, 32'h7FFF_FFFF, 1'b1),
			make_row(CMD_TAP, 10'd511, 32'h8000_0000, 9'd0, 24'd0, 17'd0),
			calc_known(9'd1, 32'h8000_0000, 1'b1),
			make_row(CMD_NOP, 10'd511, 32'h7FFF_FFFF, 9'd1, 24'hFF_FFFF, 17'h1_FFFF),
			make_row(CMD_COL, 10'd0, 32'd0, 9'd511, 24'd1, 17'h1_0000),
			calc_known(9'd511, 32'd128, 1'b0),
			calc_known(9'd1, 32'h8000_0000, 1'b1),
			make_row(CMD_COL, 10'd0, 32'd0, 9'd0, 24'd0, 17'd0),
			calc_known(9'd0, 32'd0, 1'b0)
		};
		phase_width[RAND_WIDTH_PHASE] = $urandom_range(2, MAX_WIDTH);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_width(AW_W'(2));
		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_word(directed_rows[i]);

		// Fill every tap and column so that any later compute reads written data.
		for (int i = 0; i < TAP_DEPTH; i++)
			offer_word(make_row(CMD_TAP, TAP_IDX_W'(i), shaped_tap(), '0, '0, '0));
		for (int c = 0; c < MAX_WIDTH; c++)
			offer_word(make_row(CMD_COL, '0, '0, COL_W'(c), SMP_W'($urandom),
				random_weight()));

		// Random traffic over a series of row widths.
		for (int p = 0; p < PHASES; p++) begin
			drain_row_results(SETTLE_CYCLES);
			write_width(AW_W'(phase_width[p]));
			if (p == HOLD_PHASE)
				hold_request <= 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				mode = (p * ITEMS_PER_PHASE + i) * 3 / (PHASES * ITEMS_PER_PHASE);
				if (mode != idle_mode) begin
					idle_mode = mode;
					case (mode)
						1: begin
							send_idle_pct = 57;
							recv_idle_pct <= 7;
						end
						default: begin
							send_idle_pct = 0;
							recv_idle_pct <= 0;
						end
					endcase
				end
				offer_word(random_row_word());
			end
		end

		drain_row_results(END_DRAIN);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rprf_pkg.sv
hw/rtl/rprf_ram.sv
hw/rtl/rprf_mac.sv
hw/rtl/rprf_seq.sv
hw/rtl/projection_row_ramp_filter.sv
hw/rtl/rprf_checker.sv
verif/tb_top.sv
